>>> rtl/wsd_pkg.sv
// shared types and constants of the websocket frame deframer
// result entry layout, status codes and queue depth; no dependencies
package wsd_pkg;

   localparam int QueueDepth = 4;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TRUNCATED = 2'd1,
      STATUS_FRAGMENT  = 2'd2,
      STATUS_OPCODE    = 2'd3
   } status_type;

   // one classified result on its way from the parser to the unmask stage
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic       has_byte;
      logic       last;
      status_type status;
   } entry_type;

endpackage

>>> rtl/websocket_frame_deframer.sv
// channel   direction  handshake          payload
// req       in         req_push/req_full  req_data_byte, req_end_of_buffer
// rsp       out        rsp_pop/rsp_empty  rsp_payload_byte, rsp_has_byte, rsp_last,
//                                         rsp_status
//
// one byte is accepted every cycle while req_full is low; the parser classifies it
// in the cycle it is taken, writes its result into the queue at the accepting edge,
// and the result reaches rsp through the output register
// req_full rises only when the result queue is full, so rsp stalls back up after
// QUEUE_DEPTH + 1 results; dropped bytes never occupy the queue
// reset is synchronous; it empties the queue and output register and restarts
// parsing at the first header byte
module websocket_frame_deframer
   import wsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_buffer,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic       rsp_last,
   output logic [1:0] rsp_status
);

   logic      accept;
   logic      res_valid;
   entry_type res_entry;
   logic      q_valid;
   entry_type q_head;
   logic      q_pop;
   logic      out_valid;

   assign accept = req_push && !req_full;

   wsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_buffer (req_end_of_buffer),
      .res_valid     (res_valid),
      .res_entry     (res_entry)
   );

   wsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_entry (res_entry),
      .full       (req_full),
      .valid      (q_valid),
      .head       (q_head),
      .pop        (q_pop)
   );

   wsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .out_valid        (out_valid),
      .out_payload_byte (rsp_payload_byte),
      .out_has_byte     (rsp_has_byte),
      .out_last         (rsp_last),
      .out_status       (rsp_status),
      .out_pop          (rsp_pop)
   );

   assign rsp_empty = !out_valid;

endmodule

>>> rtl/wsd_front.sv
// header parser of the websocket frame deframer: classifies each accepted byte
// and produces at most one result entry per byte; depends on wsd_pkg
module wsd_front
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       end_of_buffer,
   output logic       res_valid,
   output entry_type  res_entry
);

   typedef enum logic [5:0] {
      PH_HDR0 = 6'b000001,
      PH_HDR1 = 6'b000010,
      PH_EXT  = 6'b000100,
      PH_KEY  = 6'b001000,
      PH_DATA = 6'b010000,
      PH_DROP = 6'b100000
   } phase_type;

   localparam logic [6:0] LenExt16 = 7'd126;
   localparam logic [6:0] LenExt64 = 7'd127;

   phase_type   phase_ff, phase_in;
   logic        mask_ff, mask_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic        emit;
   entry_type   entry;

   always_comb begin
      phase_in = phase_ff;
      mask_in  = mask_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      emit     = 1'b0;
      entry    = '{data: 8'd0, key: 8'd0, has_byte: 1'b0, last: 1'b0,
                   status: STATUS_OK};
      unique case (phase_ff)
         PH_HDR0: begin
            mask_in = 1'b0;
            cnt_in  = 4'd0;
            len_in  = '0;
            key_in  = '0;
            if (end_of_buffer) begin
               emit = 1'b1;
               entry.last = 1'b1;
               entry.status = STATUS_TRUNCATED;
            end else if (!data_byte[7]) begin
               phase_in = PH_DROP;
               emit = 1'b1;
               entry.last = 1'b1;
               entry.status = STATUS_FRAGMENT;
            end else if (data_byte[3:0] >= 4'd3) begin
               phase_in = PH_DROP;
               emit = 1'b1;
               entry.last = 1'b1;
               entry.status = STATUS_OPCODE;
            end else begin
               phase_in = PH_HDR1;
            end
         end
         PH_HDR1: begin
            mask_in = data_byte[7];
            if (data_byte[6:0] == LenExt16) begin
               cnt_in   = 4'd2;
               phase_in = PH_EXT;
            end else if (data_byte[6:0] == LenExt64) begin
               cnt_in   = 4'd8;
               phase_in = PH_EXT;
            end else begin
               len_in = {57'd0, data_byte[6:0]};
               if (data_byte[7]) begin
                  cnt_in   = 4'd4;
                  phase_in = PH_KEY;
               end else if (data_byte[6:0] == 7'd0) begin
                  phase_in = PH_DROP;
                  emit = 1'b1;
                  entry.last = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_EXT: begin
            len_in = {len_ff[55:0], data_byte};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               if (mask_ff) begin
                  cnt_in   = 4'd4;
                  phase_in = PH_KEY;
               end else if (len_in == 64'd0) begin
                  phase_in = PH_DROP;
                  emit = 1'b1;
                  entry.last = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], data_byte};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               if (len_ff == 64'd0) begin
                  phase_in = PH_DROP;
                  emit = 1'b1;
                  entry.last = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            // key rotates so the byte for this position is always on top
            key_in = {key_ff[23:0], key_ff[31:24]};
            // length counts down the bytes still to come
            len_in = len_ff - 64'd1;
            emit = 1'b1;
            entry.data = data_byte;
            entry.key = key_ff[31:24];
            entry.has_byte = 1'b1;
            if (len_ff == 64'd1) begin
               phase_in = PH_DROP;
               entry.last = 1'b1;
            end else if (end_of_buffer) begin
               entry.last = 1'b1;
               entry.status = STATUS_TRUNCATED;
            end
         end
         PH_DROP: begin
         end
         default: begin
         end
      endcase
      if (end_of_buffer) begin
         // buffer ended inside a frame that gave no result on this byte
         if (!emit && phase_in != PH_DROP) begin
            emit = 1'b1;
            entry.last = 1'b1;
            entry.status = STATUS_TRUNCATED;
         end
         phase_in = PH_HDR0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff <= mask_in;
         cnt_ff  <= cnt_in;
         len_ff  <= len_in;
         key_ff  <= key_in;
      end
   end

   assign res_valid = accept && emit;
   assign res_entry = entry;

endmodule

>>> rtl/wsd_queue.sv
// short result queue between parser and unmask stage of the frame deframer
// register array with read and write pointers; depends on wsd_pkg
module wsd_queue
   import wsd_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      valid,
   output entry_type head,
   input  logic      pop
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

   entry_type         mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/wsd_back.sv
// unmask stage of the frame deframer: applies the mask key byte and holds
// the result in the output register; depends on wsd_pkg
module wsd_back
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  q_head,
   output logic       q_pop,
   output logic       out_valid,
   output logic [7:0] out_payload_byte,
   output logic       out_has_byte,
   output logic       out_last,
   output logic [1:0] out_status,
   input  logic       out_pop
);

   logic       valid_ff, valid_in;
   logic [7:0] payload_ff;
   logic       has_ff;
   logic       last_ff;
   status_type status_ff;
   logic       take;

   // refill from the queue head whenever one waits and the register is empty or drains this cycle
   assign take     = q_valid && (!valid_ff || out_pop);
   assign q_pop    = take;
   assign valid_in = take || (valid_ff && !out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         payload_ff <= q_head.data ^ q_head.key;
         has_ff     <= q_head.has_byte;
         last_ff    <= q_head.last;
         status_ff  <= q_head.status;
      end
   end

   assign out_valid        = valid_ff;
   assign out_payload_byte = payload_ff;
   assign out_has_byte     = has_ff;
   assign out_last         = last_ff;
   assign out_status       = status_ff;

endmodule

>>> rtl/wsd_checker.sv
// port-level checks for the websocket frame deframer, bound to the top level
// depends on wsd_pkg for the status codes
module wsd_checker
   import wsd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_has_byte,
   input logic       rsp_last,
   input logic [1:0] rsp_status
);

   // a waiting item stays put until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_payload_byte)
         && $stable(rsp_last) && $stable(rsp_status))
      else $error("rsp item changed while stalled");

   // an item that is not the end of a frame is always a plain payload byte
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_last |-> rsp_has_byte && rsp_status == STATUS_OK)
      else $error("non-final item without byte or with status");

   // items without a byte carry a zero byte
   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_has_byte |-> rsp_payload_byte == 8'd0)
      else $error("byte-less item with nonzero payload");

   // reset leaves both sides empty and open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue not empty after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_has_byte     (rsp_has_byte),
   .rsp_last         (rsp_last),
   .rsp_status       (rsp_status)
);

>>> tb/tb.sv
// self-checking bench for the websocket frame deframer: random read buffers of
// frames in, unmasked payload items out, checked against a byte-level parser model
// depends on wsd_pkg and websocket_frame_deframer
module tb
   import wsd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA, PH_DROP
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eob;
   } rx_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       last;
      status_type status;
   } result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_byte;
   logic       rsp_last;
   logic [1:0] rsp_status;

   rx_item_type rx_bytes[$];
   result_type  frame_results[$];
   rx_item_type nxt;
   result_type  oldest;

   int items_queued = 0;
   int items_taken = 0;
   int errors = 0;
   int send_idle = 0;
   int stall_pct = 0;
   int status_count[4] = '{0, 0, 0, 0};

   // parser model state
   phase_type   ph = PH_HDR0;
   logic        fin_flag, mask_flag;
   logic [3:0]  bytes_left;
   logic [63:0] frame_len, frame_count;
   logic [31:0] key_word;

   websocket_frame_deframer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_end_of_buffer(req_end_of_buffer),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // returns 1 when the header closes on an empty payload
   function automatic bit header_ends_empty();
      if (frame_len == 64'd0) begin
         ph = PH_DROP;
         return 1'b1;
      end
      ph = PH_DATA;
      return 1'b0;
   endfunction

   function automatic bit length_ends_empty();
      if (mask_flag) begin
         bytes_left = 4'd4;
         ph = PH_KEY;
         return 1'b0;
      end
      return header_ends_empty();
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic eob);
      result_type r;
      bit         got;
      logic [7:0] k;
      r = '0;
      r.status = STATUS_OK;
      got = 1'b0;
      case (ph)
         PH_HDR0: begin
            fin_flag = b[7];
            mask_flag = 1'b0;
            bytes_left = 4'd0;
            frame_len = 64'd0;
            key_word = 32'd0;
            frame_count = 64'd0;
            if (eob) begin
               got = 1'b1;
               r.last = 1'b1;
               r.status = STATUS_TRUNCATED;
            end else if (!b[7]) begin
               ph = PH_DROP;
               got = 1'b1;
               r.last = 1'b1;
               r.status = STATUS_FRAGMENT;
            end else if (b[3:0] >= 4'd3) begin
               ph = PH_DROP;
               got = 1'b1;
               r.last = 1'b1;
               r.status = STATUS_OPCODE;
            end else begin
               ph = PH_HDR1;
            end
         end
         PH_HDR1: begin
            mask_flag = b[7];
            if (b[6:0] == 7'd126) begin
               bytes_left = 4'd2;
               ph = PH_EXT;
            end else if (b[6:0] == 7'd127) begin
               bytes_left = 4'd8;
               ph = PH_EXT;
            end else begin
               frame_len = {57'd0, b[6:0]};
               if (length_ends_empty()) begin
                  got = 1'b1;
                  r.last = 1'b1;
               end
            end
         end
         PH_EXT: begin
            frame_len = {frame_len[55:0], b};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == 4'd0 && length_ends_empty()) begin
               got = 1'b1;
               r.last = 1'b1;
            end
         end
         PH_KEY: begin
            key_word = {key_word[23:0], b};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == 4'd0 && header_ends_empty()) begin
               got = 1'b1;
               r.last = 1'b1;
            end
         end
         PH_DATA: begin
            // key bytes rotate from the top of the stored key
            k = mask_flag ? key_word[(3 - int'(frame_count[1:0])) * 8 +: 8] : 8'd0;
            frame_count = frame_count + 64'd1;
            got = 1'b1;
            r.data = b ^ k;
            r.has_byte = 1'b1;
            if (frame_count == frame_len) begin
               ph = PH_DROP;
               r.last = 1'b1;
            end else if (eob) begin
               r.last = 1'b1;
               r.status = STATUS_TRUNCATED;
            end
         end
         default: ;
      endcase
      if (eob) begin
         // buffer ran out inside a header that gave nothing yet
         if (!got && ph != PH_DROP) begin
            got = 1'b1;
            r.last = 1'b1;
            r.status = STATUS_TRUNCATED;
         end
         ph = PH_HDR0;
      end
      if (got)
         frame_results.push_back(r);
   endtask

   task automatic add_byte(input logic [7:0] d, input logic e);
      rx_bytes.push_back('{d, e});
      items_queued++;
   endtask

   // one read buffer holding one frame, cut after byte index cut when cut >= 0
   task automatic queue_frame(input logic fin, input logic [3:0] opcode, input logic masked,
                              input logic [63:0] plen, input int form, input int trail,
                              input int cut);
      logic [7:0]  bytes[$];
      logic [31:0] key;
      int          lim;
      key = $urandom;
      lim = (cut >= 0) ? cut + 1 : 32'h7fff_ffff;
      bytes.push_back({fin, 3'($urandom), opcode});
      case (form)
         0: bytes.push_back({masked, plen[6:0]});
         1: begin
            bytes.push_back({masked, 7'd126});
            bytes.push_back(plen[15:8]);
            bytes.push_back(plen[7:0]);
         end
         default: begin
            bytes.push_back({masked, 7'd127});
            for (int i = 7; i >= 0; i--)
               bytes.push_back(plen[i * 8 +: 8]);
         end
      endcase
      if (masked)
         for (int i = 3; i >= 0; i--)
            bytes.push_back(key[i * 8 +: 8]);
      for (longint unsigned n = 0; n < plen && bytes.size() < lim; n++)
         bytes.push_back(8'($urandom));
      for (int i = 0; i < trail; i++)
         bytes.push_back(8'($urandom));
      while (bytes.size() > lim)
         void'(bytes.pop_back());
      foreach (bytes[i])
         add_byte(bytes[i], i == bytes.size() - 1);
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (items_taken != items_queued || frame_results.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
   endtask

   // driver: holds an item until it is taken, then loads the next one
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         ph = PH_HDR0;
      end else begin
         if (req_push && !req_full) begin
            deframe_byte(req_data_byte, req_end_of_buffer);
            items_taken++;
         end
         if (!req_push || !req_full) begin
            if (rx_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
               nxt = rx_bytes.pop_front();
               req_push <= 1'b1;
               req_data_byte <= nxt.data;
               req_end_of_buffer <= nxt.eob;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (frame_results.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0h/%b/%b/%0d",
                        $time, rsp_payload_byte, rsp_has_byte, rsp_last, rsp_status);
               errors++;
            end else begin
               oldest = frame_results.pop_front();
               if (rsp_payload_byte !== oldest.data)
                  report_field("payload_byte", 32'(oldest.data), 32'(rsp_payload_byte));
               if (rsp_has_byte !== oldest.has_byte)
                  report_field("has_byte", 32'(oldest.has_byte), 32'(rsp_has_byte));
               if (rsp_last !== oldest.last)
                  report_field("last", 32'(oldest.last), 32'(rsp_last));
               if (rsp_status !== oldest.status)
                  report_field("status", 32'(oldest.status), 32'(rsp_status));
               status_count[oldest.status]++;
            end
         end
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      int          target, sel, form, cut, n;
      int          idle_set[4], stall_set[4];
      logic [63:0] plen;
      logic        masked, fin;
      logic [3:0]  op;
      idle_set = '{0, 67, 0, 25};
      stall_set = '{0, 0, 67, 25};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-byte buffers are always cut short
      add_byte(8'h81, 1'b1);
      add_byte(8'h00, 1'b1);
      // non-final frame, then close frame, then reserved opcode
      add_byte(8'h01, 1'b0);
      add_byte(8'hff, 1'b1);
      add_byte(8'h88, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(8'h8f, 1'b0);
      add_byte(8'h85, 1'b1);
      // empty payload followed by a dropped byte
      queue_frame(1'b1, 4'h2, 1'b0, 64'd0, 0, 1, -1);
      queue_frame(1'b1, 4'h1, 1'b1, 64'd1, 0, 0, -1);
      // buffer ends inside a 16-bit length, and inside a 64-bit one with top bit set
      queue_frame(1'b1, 4'h0, 1'b0, 64'h0100, 1, 0, 2);
      queue_frame(1'b1, 4'h2, 1'b1, 64'h8000_0000_0000_0005, 2, 0, 5);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle = idle_set[p];
         stall_pct = stall_set[p];
         target = items_queued + 250;
         while (items_queued < target) begin
            sel = $urandom_range(99);
            masked = 1'($urandom);
            form = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 2);
            case (form)
               0: plen = ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(20);
               1: plen = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(40);
               default: plen = $urandom_range(40);
            endcase
            if (sel < 65) begin
               queue_frame(1'b1, 4'($urandom_range(2)), masked, plen, form,
                           $urandom_range(1) ? 0 : $urandom_range(1, 3), -1);
            end else if (sel < 80) begin
               if (form == 2 && $urandom_range(1))
                  plen = {$urandom, $urandom};
               cut = $urandom_range(0, 13 + ((plen > 64'd40) ? 40 : int'(plen)));
               queue_frame(1'b1, 4'($urandom_range(2)), masked, plen, form, 0, cut);
            end else if (sel < 90) begin
               fin = 1'($urandom);
               op = fin ? 4'($urandom_range(3, 15)) : 4'($urandom_range(15));
               queue_frame(fin, op, masked, 64'($urandom_range(3)), 0, $urandom_range(3), -1);
            end else begin
               n = $urandom_range(1, 6);
               for (int i = 0; i < n; i++)
                  add_byte(8'($urandom), i == n - 1);
            end
         end
         // sender holds off here until every result of the phase is back
         wait_drained();
      end

      $display("run covered %0d bytes in, %0d results", items_taken,
               status_count[0] + status_count[1] + status_count[2] + status_count[3]);
      $display("ok %0d, truncated %0d, fragment %0d, opcode %0d",
               status_count[0], status_count[1], status_count[2], status_count[3]);
      $display("idling phases: none, sender, receiver, both; %0d mismatches", errors);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
